// ===== rtl/core/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: command codes, result
// status codes and the stored word type.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;

    typedef logic [CMD_W-1:0]           t_cmd;
    typedef logic [STATUS_W-1:0]        t_status;
    typedef logic signed [WORD_W-1:0]   t_word;

    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_REAR  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_REAR   = 3'd3;
    localparam t_cmd CMD_LIST       = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage

// ===== rtl/core/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Ring store of the queue: one write port and one read port, with the read
// data registered and held until the next read is issued.
// ----------------------------------------------------------------------------
module dq_ram
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_word         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_word         o_rdata
);

    t_word mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Command sequencer of the queue. It keeps the head index and entry count,
// drives the ring store ports and owns the result output register.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_cmd          i_cmd,
    input  t_word         i_word_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_status       o_status,
    output t_word         o_word_out,
    output logic          o_last,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output t_word         o_wdata,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  t_word         i_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X  = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_head,  n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos,   n_pos;
    logic [CW-1:0] r_k,     n_k;
    logic          r_o_valid, n_o_valid;
    t_status       r_status,  n_status;
    t_word         r_word,    n_word;
    logic          r_last,    n_last;

    logic          out_free;
    logic          accept;
    logic          is_empty;
    logic          is_full;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] pos_inc;
    logic [AW:0]   rear_sum;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] rear_free;
    logic [AW-1:0] rear_used;
    logic          list_last;

    assign out_free   = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == FULL_CNT);

    assign head_inc = (r_head == LAST_POS) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? LAST_POS : r_head - AW'(1);
    assign pos_inc  = (r_pos == LAST_POS) ? '0 : r_pos + AW'(1);

    // The free slot behind the rear and the rear entry itself. Both sums
    // stay below twice the depth, so one subtract wraps them.
    assign rear_sum  = {1'b0, r_head} + (AW+1)'(r_count);
    assign tail_sum  = rear_sum - (AW+1)'(1);
    assign rear_free = (rear_sum >= DEPTH_X) ? AW'(rear_sum - DEPTH_X) : rear_sum[AW-1:0];
    assign rear_used = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];

    assign list_last = ((r_k + CW'(1)) == r_count);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_k       = r_k;
        n_o_valid = r_o_valid && !i_out_ready;
        n_status  = r_status;
        n_word    = r_word;
        n_last    = r_last;
        o_we      = 1'b0;
        o_waddr   = r_head;
        o_wdata   = i_word_in;
        o_re      = 1'b0;
        o_raddr   = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                            n_o_valid = 1'b1;
                            n_word    = '0;
                            n_last    = 1'b1;
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                o_we     = 1'b1;
                                n_count  = r_count + CW'(1);
                                if (i_cmd == CMD_PUSH_FRONT) begin
                                    n_head  = head_dec;
                                    o_waddr = head_dec;
                                end else begin
                                    o_waddr = rear_free;
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_REAR: begin
                            if (is_empty) begin
                                n_o_valid = 1'b1;
                                n_status  = ST_EMPTY;
                                n_word    = '0;
                                n_last    = 1'b1;
                            end else begin
                                o_re    = 1'b1;
                                n_count = r_count - CW'(1);
                                n_state = S_POP;
                                if (i_cmd == CMD_POP_FRONT) begin
                                    o_raddr = r_head;
                                    n_head  = head_inc;
                                end else begin
                                    o_raddr = rear_used;
                                end
                            end
                        end
                        CMD_LIST: begin
                            if (is_empty) begin
                                n_o_valid = 1'b1;
                                n_status  = ST_EMPTY;
                                n_word    = '0;
                                n_last    = 1'b1;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = r_head;
                                n_pos   = r_head;
                                n_k     = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            // Undefined commands are taken and produce no word.
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_status  = ST_OK;
                    n_word    = i_rdata;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_LIST: begin
                // The read data is held until the next read, so a stalled
                // output simply waits here.
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_status  = ST_OK;
                    n_word    = i_rdata;
                    n_last    = list_last;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = pos_inc;
                        n_pos   = pos_inc;
                        n_k     = r_k + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_status <= n_status;
        r_word   <= n_word;
        r_last   <= n_last;
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_status;
    assign o_word_out  = r_word;
    assign o_last      = r_last;

endmodule

// ===== rtl/core/double_ended_queue_top.sv =====
// A push, a refused push, or a pop or list of an empty queue gives its word in
// the cycle after acceptance; a pop's word passes the ring store read register
// and then the result register, and no command is taken meanwhile; an undefined
// command gives none. One push or list word per cycle while the output is free.
// Reset (synchronous, active low) empties the queue; the ring store is not
// cleared and no entry outside the occupied range is ever read.
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit words held in a ring store
// with a head index and an entry count.
// ----------------------------------------------------------------------------
module double_ended_queue_top
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_cmd    i_cmd,
    input  t_word   i_word_in,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_status o_status,
    output t_word   o_word_out,
    output logic    o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          we;
    logic [AW-1:0] waddr;
    t_word         wdata;
    logic          re;
    logic [AW-1:0] raddr;
    t_word         rdata;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_word_in   (i_word_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_word_out  (o_word_out),
        .o_last      (o_last),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    dq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

// ===== sim/dq_checker.sv =====
// ----------------------------------------------------------------------------
// dq_checker
// Watches both channels of the double-ended queue, keeps its own copy of the
// ring contents, predicts the results of every accepted command word and
// compares each accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dq_checker
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_ready,
    input  t_cmd    i_cmd,
    input  t_word   i_word_in,
    input  logic    i_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    input  t_word   i_word_out,
    input  logic    i_last,
    output int      o_errors,
    output int      o_pending,
    output int      o_results,
    output int      o_full_drops
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status status;
        t_word   word;
        logic    last;
    } dq_result_t;

    dq_result_t expected_q[$];
    t_word      ring_copy[DEPTH];
    int         head_pos;
    int         occupancy;
    int         err_cnt;
    int         result_cnt;
    int         full_cnt;

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        o_results    = 0;
        o_full_drops = 0;
    end

    function automatic bit log_mismatch();
        err_cnt++;
        return err_cnt <= 10;
    endfunction

    function automatic void expect_result(t_status st, t_word w, logic lst);
        dq_result_t r;
        r.status = st;
        r.word   = w;
        r.last   = lst;
        expected_q.push_back(r);
    endfunction

    task automatic predict_command(input t_cmd c, input t_word w);
        int pos;
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (occupancy >= DEPTH) begin
                    // The word is dropped and the ring is left as it was.
                    expect_result(ST_FULL, '0, 1'b1);
                    full_cnt++;
                end else begin
                    if (c == CMD_PUSH_FRONT) begin
                        head_pos = (head_pos + DEPTH - 1) % DEPTH;
                        pos = head_pos;
                    end else begin
                        pos = (head_pos + occupancy) % DEPTH;
                    end
                    ring_copy[pos] = w;
                    occupancy++;
                    expect_result(ST_OK, '0, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
                if (occupancy == 0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    if (c == CMD_POP_FRONT) begin
                        pos = head_pos;
                        head_pos = (head_pos + 1) % DEPTH;
                    end else begin
                        pos = (head_pos + occupancy - 1) % DEPTH;
                    end
                    occupancy--;
                    expect_result(ST_OK, ring_copy[pos], 1'b1);
                end
            end
            CMD_LIST: begin
                if (occupancy == 0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int k = 0; k < occupancy; k++) begin
                        expect_result(ST_OK, ring_copy[(head_pos + k) % DEPTH],
                                      k == occupancy - 1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        dq_result_t exp_r;
        result_cnt++;
        if (expected_q.size() == 0) begin
            if (log_mismatch())
                $display("[%0t] unexpected word: status %0d word %h last %0b",
                         $realtime, i_status, i_word_out, i_last);
        end else begin
            exp_r = expected_q.pop_front();
            if (i_status !== exp_r.status || i_word_out !== exp_r.word
                    || i_last !== exp_r.last) begin
                if (log_mismatch())
                    $display({"[%0t] result %0d mismatch: status exp %0d got %0d, ",
                              "word exp %h got %h, last exp %0b got %0b"},
                             $realtime, result_cnt, exp_r.status, i_status,
                             exp_r.word, i_word_out, exp_r.last, i_last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            head_pos  = 0;
            occupancy = 0;
        end else begin
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                predict_command(i_cmd, i_word_in);
        end
        o_errors     <= err_cnt;
        o_pending    <= expected_q.size();
        o_results    <= result_cnt;
        o_full_drops <= full_cnt;
    end

endmodule

// ===== sim/double_ended_queue_top_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Drives command words into the double-ended queue under changing idle
// patterns on both channels, with a long receiver hold-off and drain pauses,
// and leaves prediction and comparison to dq_checker.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;

    import dq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 16;
    localparam int RESET_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 152;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    t_cmd    in_cmd = CMD_PUSH_FRONT;
    t_word   in_word = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    t_status out_status;
    t_word   out_word;
    logic    out_last;

    int errors;
    int pending;
    int results;
    int full_drops;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_ticket;
    int hold_served;
    int idle_cycles;
    int cmd_seen[8];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    double_ended_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_cmd      (in_cmd),
        .i_word_in  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_status   (out_status),
        .o_word_out (out_word),
        .o_last     (out_last)
    );

    dq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_cmd       (in_cmd),
        .i_word_in   (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_status    (out_status),
        .i_word_out  (out_word),
        .i_last      (out_last),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_full_drops(full_drops)
    );

    // Receiver side. A new hold ticket keeps ready low for a long stretch so
    // that the queue backs up and stalls its input.
    initial begin
        hold_served = 0;
        forever begin
            @(posedge clk);
            if (hold_ticket != hold_served) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = hold_ticket;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input t_cmd c, input t_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_cmd   <= c;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cmd_seen[c]++;
    endtask

    // Sender pause until every outstanding result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic random_items(input int n);
        int   sent;
        int   r;
        int   push_pct;
        t_cmd c;
        sent = 0;
        push_pct = 50;
        while (sent < n) begin
            // Bursts biased towards pushes fill the ring; pop-heavy ones empty it.
            if (sent % 24 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            r = $urandom_range(99);
            if (r < 3)
                c = t_cmd'($urandom_range(7, 5));
            else if (r < 11)
                c = CMD_LIST;
            else if ($urandom_range(99) < push_pct)
                c = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
            else
                c = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
            send_word(c, t_word'($urandom()));
            if (c <= CMD_LIST)
                sent++;
        end
    endtask

    initial begin
        hold_ticket   = 0;
        send_idle_pct = 22;
        recv_idle_pct = 47;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue first, then the extreme values at both ends.
        send_word(CMD_POP_FRONT, 32'sh1234_5678);
        send_word(CMD_POP_REAR, '0);
        send_word(CMD_LIST, '1);
        send_word(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_word(CMD_PUSH_REAR, 32'sh8000_0000);
        send_word(CMD_PUSH_FRONT, '0);
        send_word(CMD_PUSH_REAR, '1);
        send_word(CMD_PUSH_FRONT, 32'sh5555_5555);
        send_word(CMD_PUSH_REAR, 32'shAAAA_AAAA);
        send_word(CMD_LIST, '0);
        send_word(t_cmd'(5), '1);
        send_word(t_cmd'(6), '0);
        send_word(t_cmd'(7), 32'sh0F0F_0F0F);
        send_word(CMD_POP_FRONT, '1);
        send_word(CMD_POP_REAR, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_REAR, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_REAR, '0);
        send_word(CMD_POP_REAR, '0);
        send_word(CMD_PUSH_REAR, 32'sd1);
        send_word(CMD_LIST, '0);
        send_word(CMD_POP_FRONT, '0);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            random_items(PHASE_ITEMS / 2);
            hold_ticket++;
            random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain();
        end

        repeat (8) @(posedge clk);

        $display("Sent %0d push-front, %0d push-rear, %0d pop-front, %0d pop-rear, %0d list",
                 cmd_seen[CMD_PUSH_FRONT], cmd_seen[CMD_PUSH_REAR],
                 cmd_seen[CMD_POP_FRONT], cmd_seen[CMD_POP_REAR], cmd_seen[CMD_LIST]);
        $display("and %0d undefined commands; %0d results checked, %0d pushes refused when full",
                 cmd_seen[5] + cmd_seen[6] + cmd_seen[7], results, full_drops);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results still outstanding", errors, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dq_pkg.sv
rtl/core/dq_ram.sv
rtl/core/dq_ctrl.sv
rtl/core/double_ended_queue_top.sv
sim/dq_checker.sv
sim/double_ended_queue_top_tb.sv
